### src/stsum_pkg.sv
// ----------------------------------------------------------------------------
// stsum_pkg
// Shared types and constants for the range-sum segment tree.
// ----------------------------------------------------------------------------
package stsum_pkg;

    localparam int IDX_W     = 10;
    localparam int VAL_W     = 32;
    localparam int SUM_W     = 42;
    localparam int LEN_W     = 11;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 48;

    localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

    localparam logic MODE_SET   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef logic signed [SUM_W-1:0] sum_t;

    typedef struct packed {
        logic we;
        logic re;
    } mem_ctl_t;

    typedef struct packed {
        logic start;
        logic is_query;
    } walk_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } walk_sts_t;

endpackage

### src/stsum_mem.sv
// ----------------------------------------------------------------------------
// stsum_mem
// Node store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module stsum_mem
    import stsum_pkg::*;
#(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  logic              aclk,
    input  mem_ctl_t          ctl,
    input  logic [ADDR_W-1:0] waddr,
    input  sum_t              wdata,
    input  logic [ADDR_W-1:0] raddr,
    output sum_t              rdata
);

    sum_t mem_array [DEPTH];
    sum_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (ctl.we) begin
            mem_array[waddr] <= wdata;
        end
        if (ctl.re) begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/stsum_walk.sv
// ----------------------------------------------------------------------------
// stsum_walk
// Tree sequencer: clearing pass, leaf-to-root update, bottom-up range sum.
// ----------------------------------------------------------------------------
module stsum_walk
    import stsum_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  walk_cmd_t               cmd,
    input  logic [IDX_W-1:0]        idx,
    input  logic signed [VAL_W-1:0] value,
    input  logic [IDX_W-1:0]        first,
    input  logic [IDX_W-1:0]        last,
    output walk_sts_t               sts,
    output sum_t                    total
);

    localparam int AW = $clog2(2 * MAX_ELEMENTS);
    localparam int NW = AW + 1;

    localparam logic [AW-1:0] CLR_LAST = AW'(2 * MAX_ELEMENTS - 1);
    localparam logic [AW-1:0] ROOT     = AW'(1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SRD   = 3'd2;
    localparam logic [2:0] ST_SWR   = 3'd3;
    localparam logic [2:0] ST_QLO   = 3'd4;
    localparam logic [2:0] ST_QHI   = 3'd5;
    localparam logic [2:0] ST_QEND  = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [AW-1:0] k_reg, k_next;
    logic [NW-1:0] lo_reg, lo_next;
    logic [NW-1:0] hi_reg, hi_next;
    sum_t          cur_reg, cur_next;
    sum_t          acc_reg, acc_next;
    logic          pend_reg, pend_next;

    mem_ctl_t      mem_ctl;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    sum_t          wdata;
    sum_t          rdata;

    logic [AW-1:0] parent;
    logic [NW-1:0] hi_dec;
    sum_t          value_ext;
    sum_t          acc_in;

    stsum_mem #(
        .DEPTH  (2 * MAX_ELEMENTS),
        .ADDR_W (AW)
    ) u_mem (
        .aclk  (aclk),
        .ctl   (mem_ctl),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign parent    = k_reg >> 1;
    assign hi_dec    = hi_reg - NW'(1);
    assign value_ext = {{(SUM_W - VAL_W){value[VAL_W-1]}}, value};
    assign acc_in    = pend_reg ? acc_reg + rdata : acc_reg;

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        k_next     = k_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        cur_next   = cur_reg;
        acc_next   = acc_reg;
        pend_next  = 1'b0;
        mem_ctl    = '0;
        waddr      = clr_reg;
        wdata      = '0;
        raddr      = lo_reg[AW-1:0];
        sts.busy   = 1'b1;
        sts.done   = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                mem_ctl.we = 1'b1;
                clr_next   = clr_reg + AW'(1);
                if (clr_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                sts.busy = 1'b0;
                if (cmd.start) begin
                    if (cmd.is_query) begin
                        lo_next    = NW'(MAX_ELEMENTS) + NW'(first);
                        hi_next    = NW'(MAX_ELEMENTS) + NW'(last) + NW'(1);
                        acc_next   = '0;
                        state_next = ST_QLO;
                    end else begin
                        mem_ctl.we = 1'b1;
                        waddr      = AW'(MAX_ELEMENTS) + AW'(idx);
                        wdata      = value_ext;
                        k_next     = AW'(MAX_ELEMENTS) + AW'(idx);
                        cur_next   = value_ext;
                        state_next = ST_SRD;
                    end
                end
            end
            ST_SRD: begin
                mem_ctl.re = 1'b1;
                raddr      = {k_reg[AW-1:1], ~k_reg[0]};
                state_next = ST_SWR;
            end
            ST_SWR: begin
                mem_ctl.we = 1'b1;
                waddr      = parent;
                wdata      = cur_reg + rdata;
                cur_next   = cur_reg + rdata;
                k_next     = parent;
                state_next = (parent == ROOT) ? ST_IDLE : ST_SRD;
            end
            ST_QLO: begin
                acc_next = acc_in;
                if (lo_reg < hi_reg) begin
                    if (lo_reg[0]) begin
                        mem_ctl.re = 1'b1;
                        raddr      = lo_reg[AW-1:0];
                        lo_next    = lo_reg + NW'(1);
                        pend_next  = 1'b1;
                    end
                    state_next = ST_QHI;
                end else begin
                    state_next = ST_QEND;
                end
            end
            ST_QHI: begin
                acc_next = acc_in;
                lo_next  = lo_reg >> 1;
                if (hi_reg[0]) begin
                    mem_ctl.re = 1'b1;
                    raddr      = hi_dec[AW-1:0];
                    pend_next  = 1'b1;
                    hi_next    = hi_dec >> 1;
                end else begin
                    hi_next = hi_reg >> 1;
                end
                state_next = ST_QLO;
            end
            ST_QEND: begin
                sts.done   = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign total = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg   <= k_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        cur_reg <= cur_next;
        acc_reg <= acc_next;
    end

`ifndef ASSERT_OFF
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_ctl.we && mem_ctl.re))
        else $error("node store read and written in one cycle");

    a_pend_has_read: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> $past(mem_ctl.re))
        else $error("accumulate without an issued read");

    a_swr_after_srd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWR) |-> $past(state_reg == ST_SRD))
        else $error("parent write without sibling read");
`endif

endmodule

### src/segment_tree_range_sum_top.sv
// A set beat writes the leaf, then per level reads the sibling and writes the parent;
// a query beat alternates low-bound and high-bound steps up the tree, each issuing at
// most one read, as the node store has a single read port.
// Throughput: one beat at a time; a new beat is taken while a result waits on m_.
// Reset: synchronous active-low aresetn clears control and starts a clearing pass
// over all 2*MAX_ELEMENTS nodes of the node store; s_tready stays low until it ends.
// ----------------------------------------------------------------------------
// segment_tree_range_sum_top
// Point-update, range-sum segment tree with stream input and output channels.
// ----------------------------------------------------------------------------
module segment_tree_range_sum_top
    import stsum_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [LEN_W-1:0]     cfg_wr_data,   // array_length
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // element_index[9:0], element_value[41:10], range_first[51:42],
    // range_last[61:52], zero[63:62]
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]           s_tuser,       // mode[0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,       // range_total[41:0], zero[47:42]
    output logic [0:0]           m_tuser        // bad_index[0]
);

    logic [LEN_W-1:0] len_reg;

    logic                    mode;
    logic [IDX_W-1:0]        elem_idx;
    logic signed [VAL_W-1:0] elem_val;
    logic [IDX_W-1:0]        rng_first;
    logic [IDX_W-1:0]        rng_last;

    logic s_accept;
    logic set_ok;
    logic q_bad;
    logic q_empty;

    walk_cmd_t cmd;
    walk_sts_t sts;
    sum_t      walk_total;

    logic pend_reg, pend_next;
    sum_t pend_total_reg, pend_total_next;
    logic pend_bad_reg, pend_bad_next;

    logic out_load;
    logic m_tvalid_reg, m_tvalid_next;
    sum_t m_total_reg;
    logic m_bad_reg;

    function automatic logic idx_ok(input logic [IDX_W-1:0] i, input logic [LEN_W-1:0] len);
        return ({1'b0, i} < len) && (32'(i) < 32'(MAX_ELEMENTS));
    endfunction

    assign mode      = s_tuser[0];
    assign elem_idx  = s_tdata[9:0];
    assign elem_val  = s_tdata[41:10];
    assign rng_first = s_tdata[51:42];
    assign rng_last  = s_tdata[61:52];

    assign s_tready = !sts.busy && !pend_reg;
    assign s_accept = s_tvalid && s_tready;

    assign set_ok  = idx_ok(elem_idx, len_reg);
    assign q_bad   = !idx_ok(rng_first, len_reg) || !idx_ok(rng_last, len_reg);
    assign q_empty = rng_first > rng_last;

    assign cmd.is_query = (mode == MODE_QUERY);
    assign cmd.start    = s_accept &&
                          ((mode == MODE_SET && set_ok) ||
                           (mode == MODE_QUERY && !q_bad && !q_empty));

    stsum_walk #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_walk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .idx     (elem_idx),
        .value   (elem_val),
        .first   (rng_first),
        .last    (rng_last),
        .sts     (sts),
        .total   (walk_total)
    );

    assign out_load = pend_reg && (!m_tvalid_reg || m_tready);

    always_comb begin
        pend_next       = pend_reg;
        pend_total_next = pend_total_reg;
        pend_bad_next   = pend_bad_reg;
        if (out_load) begin
            pend_next = 1'b0;
        end
        if (s_accept && !cmd.start) begin
            pend_next       = 1'b1;
            pend_total_next = '0;
            pend_bad_next   = (mode == MODE_SET) ? 1'b1 : q_bad;
        end
        if (sts.done) begin
            pend_next       = 1'b1;
            pend_total_next = walk_total;
            pend_bad_next   = 1'b0;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= LEN_RESET;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                len_reg <= cfg_wr_data;
            end
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_total_reg <= pend_total_next;
        pend_bad_reg   <= pend_bad_next;
        if (out_load) begin
            m_total_reg <= pend_total_reg;
            m_bad_reg   <= pend_bad_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - SUM_W){1'b0}}, m_total_reg};
    assign m_tuser  = m_bad_reg;

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the range-sum segment tree. It keeps a flat copy of
// the element array, works out each expected range total or index error, and
// checks every m_ beat against it in order. Directed beats hit the value and
// index extremes and the length corner cases. Random phases then run over
// several array lengths, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import stsum_pkg::*;

    localparam int MAX_ELEMENTS  = 1024;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_BEATS   = 120;

    typedef struct {
        sum_t total;
        logic bad;
    } range_result_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [LEN_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic [0:0]           s_tuser     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;

    logic signed [VAL_W-1:0] element_mirror [MAX_ELEMENTS] = '{default: '0};
    logic [LEN_W-1:0]        length_reg = LEN_RESET;
    range_result_t           expected_totals [$];

    int error_count = 0;
    int cycle_count = 0;
    int send_burst  = 0;
    int recv_burst  = 0;

    segment_tree_range_sum_top #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int active_length();
        return (int'(length_reg) > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(length_reg);
    endfunction

    function automatic int draw_wait(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 15);
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: begin
                return 32'sh7FFFFFFF;
            end
            1: begin
                return 32'sh80000000;
            end
            2: begin
                return $urandom_range(0, 200) - 100;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    task automatic compute_range_result(input logic mode, input logic [IDX_W-1:0] idx,
                                        input logic signed [VAL_W-1:0] val,
                                        input logic [IDX_W-1:0] first,
                                        input logic [IDX_W-1:0] last);
        int            len;
        longint        acc;
        range_result_t res;
        len       = active_length();
        res.total = '0;
        res.bad   = 1'b0;
        if (mode == MODE_SET) begin
            if (int'(idx) < len) begin
                element_mirror[idx] = val;
                return;
            end
            res.bad = 1'b1;
        end else if (int'(first) >= len || int'(last) >= len) begin
            res.bad = 1'b1;
        end else if (first <= last) begin
            acc = 0;
            for (int i = int'(first); i <= int'(last); i++) begin
                acc += longint'(element_mirror[i]);
            end
            res.total = sum_t'(acc);
        end
        expected_totals.push_back(res);
    endtask

    task automatic send_beat(input logic mode, input logic [IDX_W-1:0] idx,
                             input logic signed [VAL_W-1:0] val,
                             input logic [IDX_W-1:0] first, input logic [IDX_W-1:0] last);
        int gap;
        gap = draw_wait(send_burst);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, last, first, val, idx};
        s_tuser  <= mode;
        do @(posedge aclk); while (!s_tready);
        compute_range_result(mode, idx, val, first, last);
        @(negedge aclk);
    endtask

    task automatic set_element(input logic [IDX_W-1:0] idx, input logic signed [VAL_W-1:0] val);
        send_beat(MODE_SET, idx, val, IDX_W'($urandom), IDX_W'($urandom));
    endtask

    task automatic query_range(input logic [IDX_W-1:0] first, input logic [IDX_W-1:0] last);
        send_beat(MODE_QUERY, IDX_W'($urandom), $urandom, first, last);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_totals.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] len);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        length_reg  = len;
    endtask

    task automatic test_cleared_store();
        query_range(0, 1023);
        query_range(1023, 1023);
        query_range(0, 0);
    endtask

    task automatic test_extreme_values();
        set_element(0, 32'sh7FFFFFFF);
        set_element(1023, 32'sh80000000);
        set_element(511, 32'sh7FFFFFFF);
        set_element(512, -1);
        query_range(0, 1023);
        query_range(1023, 1023);
        query_range(1, 1022);
        query_range(511, 512);
        query_range(600, 3);
    endtask

    task automatic test_length_limits();
        write_length(0);
        set_element(0, 5);
        query_range(0, 0);
        write_length(1);
        set_element(0, -7);
        query_range(0, 0);
        set_element(1, 9);
        query_range(1, 0);
        query_range(0, 1);
        write_length(2047);
        query_range(0, 1023);
        write_length(LEN_RESET);
    endtask

    task automatic test_random_traffic();
        logic [LEN_W-1:0] phase_lengths [8];
        int len;
        int beats;
        int r;
        int a;
        int b;
        int tmp;
        phase_lengths = '{11'd1024, 11'd40, 11'($urandom_range(1, 1024)), 11'd2,
                          11'd2047, 11'($urandom_range(3, 40)), 11'd1024, 11'd1};
        foreach (phase_lengths[p]) begin
            write_length(phase_lengths[p]);
            len   = active_length();
            beats = 0;
            if (len <= 64) begin
                for (int i = 0; i < len; i++) begin
                    set_element(IDX_W'(i), pick_value());
                    beats++;
                end
            end
            while (beats < PHASE_BEATS) begin
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    if ($urandom_range(0, 9) != 0) begin
                        set_element(IDX_W'($urandom_range(0, len - 1)), pick_value());
                    end else begin
                        set_element(IDX_W'($urandom_range(0, MAX_ELEMENTS - 1)),
                                    pick_value());
                    end
                end else if (r < 92) begin
                    a = $urandom_range(0, len - 1);
                    b = $urandom_range(0, len - 1);
                    if (a > b && $urandom_range(0, 7) != 0) begin
                        tmp = a;
                        a   = b;
                        b   = tmp;
                    end
                    query_range(IDX_W'(a), IDX_W'(b));
                end else begin
                    query_range(IDX_W'($urandom_range(0, MAX_ELEMENTS - 1)),
                                IDX_W'($urandom_range(0, MAX_ELEMENTS - 1)));
                end
                beats++;
            end
        end
    endtask

    initial begin
        int stall;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = draw_wait(recv_burst);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        range_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_totals.size() == 0) begin
                $display("%0t: unexpected beat: expected none, got total %0d bad %0b",
                         $time, $signed(m_tdata[SUM_W-1:0]), m_tuser[0]);
                error_count++;
            end else begin
                want = expected_totals.pop_front();
                if (m_tdata[SUM_W-1:0] !== want.total) begin
                    $display("%0t: range_total mismatch: expected %0d, got %0d",
                             $time, want.total, $signed(m_tdata[SUM_W-1:0]));
                    error_count++;
                end
                if (m_tuser[0] !== want.bad) begin
                    $display("%0t: bad_index mismatch: expected %0b, got %0b",
                             $time, want.bad, m_tuser[0]);
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        test_cleared_store();
        test_extreme_values();
        test_length_limits();
        test_random_traffic();
        wait_idle();
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### files.f
src/stsum_pkg.sv
src/stsum_mem.sv
src/stsum_walk.sv
src/segment_tree_range_sum_top.sv
verif/tb_top.sv
